@@ hdl/sat_pkg.sv @@
package sat_pkg;

	localparam int MAX_SECTIONS = 16;
	localparam int ADDR_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

	localparam int CMD_W = 2;
	localparam int IDX_W = 4;
	localparam int ADR_W = 32;
	localparam int CFG_W = 5;
	localparam int S_TDATA_W = 136;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_V2F = 2'd1;
	localparam logic [CMD_W-1:0] CMD_F2V = 2'd2;

	// one section: virtual base, raw pointer, raw size
	typedef struct packed {
		logic [ADR_W-1:0] size;
		logic [ADR_W-1:0] raw;
		logic [ADR_W-1:0] virt;
	} sec_entry_t;

	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		sec_entry_t data;
	} mem_wr_t;

	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

endpackage

@@ hdl/sat_section_mem.sv @@
module sat_section_mem (
	input logic clk,
	input logic arst_n,
	input sat_pkg::mem_wr_t wr,
	input sat_pkg::mem_rd_t rd,
	output sat_pkg::sec_entry_t rd_data
);

	sat_pkg::sec_entry_t mem [sat_pkg::MAX_SECTIONS];
	logic [sat_pkg::MAX_SECTIONS-1:0] valid_q;
	sat_pkg::sec_entry_t data_q;
	logic vld_rd_q;

	// entry storage, registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			data_q <= mem[rd.addr];
		end
	end

	// valid bits: a never-written entry reads as all zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				vld_rd_q <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = vld_rd_q ? data_q : '0;

endmodule

@@ hdl/section_address_translator_core.sv @@
// section address translator
//
// channels
//   cfg    : write of section_count (number of active table entries), always ready
//   s_axis : one request per item; tuser carries the command (write entry,
//            virtual to file offset, file offset to virtual)
//   m_axis : exactly one result per request, result_addr in tdata, hit in tuser
//
// request flow
//   one request in work at a time, the next one taken the cycle after its result
//   is registered. a write, an unused command, a header address or an empty
//   table goes straight to its result without a table walk. a translation
//   reads one entry per cycle through the registered table read and stops at
//   the first matching entry, or on a miss after the last active entry
//
// reset
//   arst_n clears the table (valid bits), section_count and all handshakes
// stalls
//   the result sits in an output register; the next request is taken while it
//   waits, and a new result is held back until the output register is free
module section_address_translator_core (
	input logic clk,
	input logic arst_n,

	// config write channel
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [sat_pkg::CFG_W-1:0] cfg_data, // section_count

	// request channel
	input logic s_tvalid,
	output logic s_tready,
	// tdata from bit 0: entry_index[3:0], virt_base[35:4], raw_base[67:36],
	// raw_length[99:68], query_addr[131:100], zero pad[135:132]
	input logic [sat_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [sat_pkg::CMD_W-1:0] s_tuser, // cmd

	// result channel
	output logic m_tvalid,
	input logic m_tready,
	output logic [sat_pkg::ADR_W-1:0] m_tdata, // result_addr
	output logic m_tuser // hit
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t state_q;

	// request fields
	logic [sat_pkg::IDX_W-1:0] in_idx;
	logic [sat_pkg::ADR_W-1:0] in_virt, in_raw, in_len, in_query;
	assign in_idx = s_tdata[3:0];
	assign in_virt = s_tdata[35:4];
	assign in_raw = s_tdata[67:36];
	assign in_len = s_tdata[99:68];
	assign in_query = s_tdata[131:100];

	logic [sat_pkg::CFG_W-1:0] count_q;
	logic [sat_pkg::ADR_W-1:0] raw0_q; // copy of entry 0 raw pointer for the header test

	logic [sat_pkg::ADR_W-1:0] query_q;
	logic f2v_q; // direction: file offset to virtual
	logic [sat_pkg::CNT_W-1:0] n_q;
	logic [sat_pkg::CNT_W-1:0] issue_q;
	logic pend_s1; // read data for the previous issue is on rd_data
	logic [sat_pkg::ADR_W-1:0] res_q;
	logic hit_q;

	logic m_tvalid_q;
	logic [sat_pkg::ADR_W-1:0] m_tdata_q;
	logic m_tuser_q;

	sat_pkg::mem_wr_t wr;
	sat_pkg::mem_rd_t rd;
	sat_pkg::sec_entry_t rd_data;

	logic s_acc;
	logic idx_ok;
	logic out_free;
	logic [sat_pkg::CNT_W-1:0] n_clamp;

	// translation datapath on the entry just read
	logic [sat_pkg::ADR_W-1:0] base, other, end_addr, rebased;
	logic match;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign idx_ok = 32'(in_idx) < 32'(sat_pkg::MAX_SECTIONS);
	// a count above the table depth acts as the depth
	assign n_clamp = (32'(count_q) > 32'(sat_pkg::MAX_SECTIONS)) ?
		sat_pkg::CNT_W'(sat_pkg::MAX_SECTIONS) : sat_pkg::CNT_W'(count_q);

	always_comb begin
		wr.en = s_acc && (s_tuser == sat_pkg::CMD_WRITE) && idx_ok;
		wr.addr = sat_pkg::ADDR_W'(in_idx);
		wr.data.virt = in_virt;
		wr.data.raw = in_raw;
		wr.data.size = in_len;
		rd.en = (state_q == ST_WALK) && (issue_q < n_q);
		rd.addr = issue_q[sat_pkg::ADDR_W-1:0];
	end

	always_comb begin
		base = f2v_q ? rd_data.raw : rd_data.virt;
		other = f2v_q ? rd_data.virt : rd_data.raw;
		end_addr = base + rd_data.size; // wraps; a wrapped range matches nothing
		match = (query_q >= base) && (query_q < end_addr);
		rebased = (query_q - base) + other;
	end

	sat_section_mem u_mem (
		.clk (clk),
		.arst_n (arst_n),
		.wr (wr),
		.rd (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			raw0_q <= '0;
			issue_q <= '0;
			pend_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (wr.en && (in_idx == '0)) begin
				raw0_q <= in_raw;
			end
			// load a new result or drop the one just taken
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					pend_s1 <= 1'b0;
					if (s_acc) begin
						if ((s_tuser == sat_pkg::CMD_V2F || s_tuser == sat_pkg::CMD_F2V)
							&& (in_query >= raw0_q) && (n_clamp != '0)) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (rd.en) begin
						issue_q <= issue_q + 1'b1;
					end
					// first match wins; a miss ends after the last entry is tested
					if (pend_s1 && (match || (issue_q >= n_q))) begin
						state_q <= ST_DONE;
						pend_s1 <= 1'b0;
					end else begin
						pend_s1 <= rd.en;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			query_q <= in_query;
			f2v_q <= (s_tuser == sat_pkg::CMD_F2V);
			n_q <= n_clamp;
			if ((s_tuser == sat_pkg::CMD_V2F || s_tuser == sat_pkg::CMD_F2V)
				&& (in_query < raw0_q)) begin
				// header address passes through
				res_q <= in_query;
				hit_q <= 1'b1;
			end else begin
				res_q <= '0;
				hit_q <= 1'b0;
			end
		end
		if (state_q == ST_WALK && pend_s1 && match) begin
			res_q <= rebased;
			hit_q <= 1'b1;
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= res_q;
			m_tuser_q <= hit_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	// a miss or a write always reports a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("miss result with nonzero address");

	// a table write never starts a walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == sat_pkg::CMD_WRITE) |=> (state_q == ST_DONE))
		else $error("write request did not go straight to result");

	// no new request while table data is still in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !s_tready)
		else $error("request accepted during table walk");

	// pending read data always follows an issued read
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (issue_q != '0))
		else $error("pending read without an issued address");

endmodule

@@ verif/section_address_translator_core_tb.sv @@
`timescale 1ns / 1ps

module section_address_translator_core_tb;
	import sat_pkg::*;

	// cmd 3 has no meaning in the block, it only returns a zero miss
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// kinds of rows in the directed plan
	localparam bit ROW_REQ = 1'b0;
	localparam bit ROW_CFG = 1'b1;
	// where the expected result of a directed row comes from
	localparam bit CHK_PRED = 1'b0;
	localparam bit CHK_TYPED = 1'b1;

	localparam int N_PLAN = 25;

	// one translation result as the block returns it
	typedef struct packed {
		logic [ADR_W-1:0] addr;
		logic hit;
	} xlat_t;

	// one row of the directed plan: a section_count write or a request
	typedef struct packed {
		bit kind;
		logic [CFG_W-1:0] cfg_val;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		logic [ADR_W-1:0] virt;
		logic [ADR_W-1:0] raw;
		logic [ADR_W-1:0] len;
		logic [ADR_W-1:0] query;
		bit chk;
		logic [ADR_W-1:0] t_addr;
		logic t_hit;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [ADR_W-1:0] m_tdata;
	logic m_tuser;

	// shadow of the section table and of section_count
	sec_entry_t sec_tab [MAX_SECTIONS];
	logic [CFG_W-1:0] sec_count;

	// translations accepted but not yet returned, oldest first
	xlat_t xlat_due [$];

	plan_row_t plan [N_PLAN];

	// idle chances in percent per cycle, changed between phases
	int tx_idle_pct = 8;
	int rx_stall_pct = 59;
	int n_fail = 0;

	section_address_translator_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("section_address_translator_core test failed");
		$finish;
	end

	// header test first, then the first active section whose range holds addr,
	// rebased onto the other base; sums wrap at 32 bits
	function automatic xlat_t translate_addr(input logic [CMD_W-1:0] cmd,
			input logic [ADR_W-1:0] addr);
		xlat_t r;
		int n;
		logic [ADR_W-1:0] from_b;
		logic [ADR_W-1:0] to_b;
		logic [ADR_W-1:0] end_a;
		r = '0;
		n = (sec_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(sec_count);
		// header addresses always go by entry 0, even with no active entries
		if (addr < sec_tab[0].raw) begin
			r.addr = addr;
			r.hit = 1'b1;
			return r;
		end
		for (int k = 0; k < n; k++) begin
			from_b = (cmd == CMD_V2F) ? sec_tab[k].virt : sec_tab[k].raw;
			to_b = (cmd == CMD_V2F) ? sec_tab[k].raw : sec_tab[k].virt;
			// a range whose end wraps past zero never matches
			end_a = from_b + sec_tab[k].size;
			if (addr >= from_b && addr < end_a) begin
				r.addr = addr - from_b + to_b;
				r.hit = 1'b1;
				return r;
			end
		end
		return r;
	endfunction

	// applies one request to the shadow table and returns its result
	function automatic xlat_t apply_request(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx, input logic [ADR_W-1:0] vb,
			input logic [ADR_W-1:0] rb, input logic [ADR_W-1:0] rl,
			input logic [ADR_W-1:0] q);
		xlat_t r;
		r = '0;
		case (cmd)
			CMD_WRITE: begin
				if (idx < MAX_SECTIONS)
					sec_tab[idx] = '{size: rl, raw: rb, virt: vb};
			end
			CMD_V2F, CMD_F2V: begin
				r = translate_addr(cmd, q);
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

	// called right after a rising edge; leaves s_tvalid high after acceptance
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [ADR_W-1:0] vb, input logic [ADR_W-1:0] rb,
			input logic [ADR_W-1:0] rl, input logic [ADR_W-1:0] q,
			input bit chk, input xlat_t typed_res);
		xlat_t due;
		if ($urandom_range(0, 63) == 0) begin
			// hold off until every pending result has come back
			s_tvalid <= 1'b0;
			do @(posedge clk); while (xlat_due.size() != 0);
		end else if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, q, rl, rb, vb, idx};
		do @(posedge clk); while (!s_tready);
		due = apply_request(cmd, idx, vb, rb, rl, q);
		if (chk == CHK_TYPED)
			due = typed_res;
		xlat_due.push_back(due);
	endtask

	// section_count is only written with nothing in flight
	task automatic write_section_count(input logic [CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		while (xlat_due.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sec_count = val;
		cfg_valid <= 1'b0;
	endtask

	// a plausible section: sparse virtual layout, packed raw layout,
	// entry 0 puts the header boundary near 0x4000
	task automatic load_section(input int k);
		logic [ADR_W-1:0] vb;
		logic [ADR_W-1:0] rb;
		vb = ((k + 1) << 16) | ($urandom_range(0, 255) << 4);
		rb = ((k + 1) << 14) + ($urandom_range(0, 63) << 4);
		send_request(CMD_WRITE, k[IDX_W-1:0], vb, rb, $urandom_range(1, 32'h3C00), $urandom,
			CHK_PRED, '0);
	endtask

	// one random phase: fresh table, then mostly targeted translations
	task automatic run_phase(input logic [CFG_W-1:0] count_val, input int n_req,
			input int tx_pct, input int rx_pct);
		int k;
		int sel;
		logic [CMD_W-1:0] cmd;
		logic [ADR_W-1:0] base;
		logic [ADR_W-1:0] len;
		logic [ADR_W-1:0] q;
		write_section_count(count_val);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (k = 0; k < MAX_SECTIONS; k++)
			load_section(k);
		for (int i = MAX_SECTIONS; i < n_req; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				load_section($urandom_range(0, MAX_SECTIONS - 1));
			end else if (sel < 12) begin
				// noise write, any values, wrapping ranges included
				send_request(CMD_WRITE, IDX_W'($urandom), $urandom, $urandom, $urandom,
					$urandom, CHK_PRED, '0);
			end else if (sel < 16) begin
				send_request(CMD_UNUSED, IDX_W'($urandom), $urandom, $urandom, $urandom,
					$urandom, CHK_PRED, '0);
			end else begin
				cmd = $urandom_range(0, 1) ? CMD_V2F : CMD_F2V;
				k = $urandom_range(0, MAX_SECTIONS - 1);
				base = (cmd == CMD_V2F) ? sec_tab[k].virt : sec_tab[k].raw;
				len = sec_tab[k].size;
				case ($urandom_range(0, 7))
					0: q = base;
					1: q = base + len - 1;
					2: q = base + len;
					3: q = base - 1;
					4: q = $urandom_range(0, sec_tab[0].raw);
					5: q = $urandom;
					default: q = base + $urandom_range(0, len - 1);
				endcase
				send_request(cmd, IDX_W'($urandom), $urandom, $urandom, $urandom, q,
					CHK_PRED, '0);
			end
		end
	endtask

	// result side: random stalls, every accepted result checked in order
	initial begin
		xlat_t want;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (xlat_due.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected result: addr %h hit %b", m_tdata, m_tuser);
				end else begin
					want = xlat_due.pop_front();
					if (m_tdata !== want.addr || m_tuser !== want.hit) begin
						n_fail++;
						if (n_fail <= 10)
							$display("mismatch: expected addr %h hit %b, got addr %h hit %b",
								want.addr, want.hit, m_tdata, m_tuser);
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	initial begin
		xlat_t typed_res;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_WRITE;
		for (int k = 0; k < MAX_SECTIONS; k++)
			sec_tab[k] = '0;
		sec_count = '0;

		// directed plan, section_count starts at 0
		// empty table: nothing below a zero header boundary, no entries
		plan[0] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			CHK_TYPED, 32'h0, 1'b0};
		plan[1] = '{ROW_REQ, 5'd0, CMD_F2V, 4'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
			CHK_TYPED, 32'h0, 1'b0};
		plan[2] = '{ROW_REQ, 5'd0, CMD_WRITE, 4'd0, 32'h0000_1000, 32'h0000_0400,
			32'h0000_0200, 32'h0, CHK_TYPED, 32'h0, 1'b0};
		// header passthrough with no active entries
		plan[3] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_03FF,
			CHK_TYPED, 32'h0000_03FF, 1'b1};
		plan[4] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1000,
			CHK_TYPED, 32'h0, 1'b0};
		plan[5] = '{ROW_CFG, 5'd1, CMD_WRITE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			CHK_PRED, 32'h0, 1'b0};
		// first byte, last byte and one past the end of entry 0
		plan[6] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1000,
			CHK_PRED, 32'h0, 1'b0};
		plan[7] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_11FF,
			CHK_PRED, 32'h0, 1'b0};
		plan[8] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1200,
			CHK_PRED, 32'h0, 1'b0};
		plan[9] = '{ROW_REQ, 5'd0, CMD_F2V, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_0400,
			CHK_PRED, 32'h0, 1'b0};
		// top entry whose raw range wraps past zero
		plan[10] = '{ROW_REQ, 5'd0, CMD_WRITE, 4'd15, 32'hFFFF_F000, 32'hFFFF_FF00,
			32'h0000_0100, 32'h0, CHK_TYPED, 32'h0, 1'b0};
		// count above the table size acts as a full table
		plan[11] = '{ROW_CFG, 5'd31, CMD_WRITE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			CHK_PRED, 32'h0, 1'b0};
		plan[12] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_F0FF,
			CHK_PRED, 32'h0, 1'b0};
		plan[13] = '{ROW_REQ, 5'd0, CMD_F2V, 4'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FF80,
			CHK_PRED, 32'h0, 1'b0};
		plan[14] = '{ROW_REQ, 5'd0, CMD_WRITE, 4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, CHK_TYPED, 32'h0, 1'b0};
		// unused command with all-ones and all-zeros fields
		plan[15] = '{ROW_REQ, 5'd0, CMD_UNUSED, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, CHK_TYPED, 32'h0, 1'b0};
		plan[16] = '{ROW_REQ, 5'd0, CMD_UNUSED, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			CHK_TYPED, 32'h0, 1'b0};
		plan[17] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
			CHK_PRED, 32'h0, 1'b0};
		// overlapping entries, the lower index wins
		plan[18] = '{ROW_REQ, 5'd0, CMD_WRITE, 4'd3, 32'h0000_1000, 32'h0000_8000,
			32'h0000_0100, 32'h0, CHK_TYPED, 32'h0, 1'b0};
		plan[19] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1080,
			CHK_PRED, 32'h0, 1'b0};
		plan[20] = '{ROW_CFG, 5'd16, CMD_WRITE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			CHK_PRED, 32'h0, 1'b0};
		plan[21] = '{ROW_REQ, 5'd0, CMD_F2V, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_8010,
			CHK_PRED, 32'h0, 1'b0};
		// zero header boundary: nothing is a header address any more
		plan[22] = '{ROW_REQ, 5'd0, CMD_WRITE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			CHK_TYPED, 32'h0, 1'b0};
		plan[23] = '{ROW_REQ, 5'd0, CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			CHK_PRED, 32'h0, 1'b0};
		plan[24] = '{ROW_REQ, 5'd0, CMD_F2V, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_8000,
			CHK_PRED, 32'h0, 1'b0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles little, receiver stalls often
		tx_idle_pct = 8;
		rx_stall_pct = 59;
		for (int i = 0; i < N_PLAN; i++) begin
			if (plan[i].kind == ROW_CFG) begin
				write_section_count(plan[i].cfg_val);
			end else begin
				typed_res.addr = plan[i].t_addr;
				typed_res.hit = plan[i].t_hit;
				send_request(plan[i].cmd, plan[i].idx, plan[i].virt, plan[i].raw, plan[i].len,
					plan[i].query, plan[i].chk, typed_res);
			end
		end

		run_phase(5'd16, 150, 8, 59);
		run_phase(5'd31, 150, 8, 59);
		run_phase(5'd0, 150, 8, 59);
		// now the other way round
		run_phase(CFG_W'($urandom_range(2, 15)), 150, 59, 8);
		run_phase(5'd17, 150, 59, 8);
		// and back to back with no idling
		run_phase(5'd1, 150, 0, 0);
		run_phase(5'd16, 150, 0, 0);

		s_tvalid <= 1'b0;
		while (xlat_due.size() != 0) @(posedge clk);
		// longest walk plus output register
		repeat (24) @(posedge clk);
		if (n_fail == 0)
			$display("section_address_translator_core test passed");
		else
			$display("section_address_translator_core test failed");
		$finish;
	end

endmodule
